// File: rtl/wavp_pkg.sv
// Shared types and constants for the mono PCM16 WAV stream parser.
`default_nettype none

package wavp_pkg;

	// Chunk identifiers as they appear little-endian in a 32-bit word.
	localparam logic [31:0] ID_RIFF = 32'h4646_4952;
	localparam logic [31:0] ID_WAVE = 32'h4556_4157;
	localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
	localparam logic [31:0] ID_DATA = 32'h6174_6164;

	localparam logic [31:0] FMT_MIN      = 32'd16;
	localparam logic [31:0] RIFF_MIN     = 32'd4;
	localparam logic [15:0] FMT_PCM      = 16'd1;
	localparam logic [15:0] FMT_CHANNELS = 16'd1;
	localparam logic [15:0] FMT_BITS     = 16'd16;
	localparam logic [15:0] FMT_ALIGN    = 16'd2;

	localparam int STATUS_W = 3;

	localparam logic [STATUS_W-1:0] ST_NONE   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ACCEPT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RIFF   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FMT    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DATA   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd5;
	localparam logic [STATUS_W-1:0] ST_TRUNC  = 3'd6;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_CHUNK,
		PH_FMT,
		PH_EXTRA,
		PH_SKIP,
		PH_PAD,
		PH_DATA
	} phase_t;

	typedef logic [3:0][31:0] fmt_words_t;

	// Word 0: format | channels << 16, word 1: rate, word 2: byte rate,
	// word 3: block align | bits << 16.
	function automatic logic fmt_ok(input fmt_words_t fw);
		fmt_ok = (fw[0][15:0] == FMT_PCM) && (fw[0][31:16] == FMT_CHANNELS) &&
			(fw[3][31:16] == FMT_BITS) && (fw[1] != 32'd0) &&
			(fw[3][15:0] == FMT_ALIGN) && (fw[2] == {fw[1][30:0], 1'b0});
	endfunction

endpackage

`default_nettype wire

// File: rtl/wav_mono_pcm16_stream_parser_core.sv
// Top level of the mono PCM16 WAV stream parser.
`default_nettype none

// Parses a WAV file presented one byte per request, with end_of_file on the
// last byte. Samples of the data chunk are sent out as soon as their high
// byte arrives; the byte that ends the data chunk also carries the accept
// status and the sample rate, and any header, fmt or data error, an empty
// data chunk, or a file that ends early gives a single reject status. After
// a status the parser drops bytes until end_of_file and then starts on the
// next file. One byte can be taken every clock cycle while results are taken;
// a result held in the output register and not taken stalls the input, even
// for bytes that give no result. A byte passes an input register and then a
// result register before its result is on the outputs; the parse state
// update is combinational logic on the input register.
module wav_mono_pcm16_stream_parser_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    data_byte,
	input  logic                          end_of_file,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          sample_valid,
	output logic signed [15:0]            sample,
	output logic [wavp_pkg::STATUS_W-1:0] status,
	output logic [31:0]                   sample_rate
);
	import wavp_pkg::*;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;

	// Parse state
	phase_t     phase_q;
	logic [3:0] pos_q;
	logic [31:0] id_q;
	logic [31:0] len_q;
	fmt_words_t fw_q;
	logic       seen_q;
	logic [7:0] low_q;
	logic       verdict_q;

	// Result register
	logic                out_valid_q;
	logic                smp_vld_q;
	logic [15:0]         smp_q;
	logic [STATUS_W-1:0] st_q;
	logic [31:0]         rate_q;

	// Next state
	phase_t     phase_d;
	logic [3:0] pos_d;
	logic [31:0] id_d;
	logic [31:0] len_d;
	fmt_words_t fw_d;
	logic       seen_d;
	logic [7:0] low_d;

	logic                st_c;
	logic [STATUS_W-1:0] status_c;
	logic                smp_vld_c;
	logic [15:0]         smp_c;
	logic [31:0]         part;
	logic [31:0]         len_dec;
	logic                body_end;
	logic                finish;
	logic                end_pad;
	logic                out_free;
	logic                fire_s1;
	logic                result_c;
	logic                restart;

	assign out_free = !out_valid_q || out_ready;
	assign fire_s1  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || fire_s1;

	assign part    = {24'd0, byte_s1} << {pos_q[1:0], 3'b000};
	assign len_dec = len_q - 32'd1;

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		id_d      = id_q;
		len_d     = len_q;
		fw_d      = fw_q;
		seen_d    = seen_q;
		low_d     = low_q;
		status_c  = ST_NONE;
		smp_vld_c = 1'b0;
		smp_c     = 16'd0;
		body_end  = 1'b0;
		end_pad   = 1'b0;
		finish    = 1'b0;
		st_c      = 1'b0;

		unique case (phase_q)
			PH_HEADER: begin
				if (pos_q < 4'd4 || pos_q >= 4'd8) begin
					id_d = id_q | part;
				end else begin
					len_d = len_q | part;
				end
				pos_d = pos_q + 4'd1;
				if (pos_q == 4'd3) begin
					if (id_d != ID_RIFF) status_c = ST_RIFF;
					id_d = 32'd0;
				end else if (pos_q == 4'd7) begin
					if (len_d < RIFF_MIN) status_c = ST_RIFF;
				end else if (pos_q >= 4'd11) begin
					if (id_d != ID_WAVE) begin
						status_c = ST_RIFF;
					end else begin
						phase_d = PH_CHUNK;
						pos_d   = 4'd0;
						id_d    = 32'd0;
						len_d   = 32'd0;
					end
				end
			end
			PH_CHUNK: begin
				if (pos_q < 4'd4) begin
					id_d = id_q | part;
				end else begin
					len_d = len_q | part;
				end
				pos_d = pos_q + 4'd1;
				if (pos_q >= 4'd7) begin
					if (id_d == ID_FMT) begin
						if (len_d < FMT_MIN) begin
							status_c = ST_FMT;
						end else begin
							fw_d    = '0;
							len_d   = len_d - FMT_MIN;
							pos_d   = 4'd0;
							phase_d = PH_FMT;
						end
					end else if (id_d == ID_DATA) begin
						if (!seen_q || len_d[0]) begin
							status_c = ST_DATA;
						end else if (len_d == 32'd0) begin
							status_c = ST_EMPTY;
						end else begin
							pos_d   = 4'd0;
							phase_d = PH_DATA;
						end
					end else begin
						pos_d = {3'd0, len_d[0]};
						if (len_d == 32'd0) begin
							phase_d = PH_CHUNK;
							pos_d   = 4'd0;
							id_d    = 32'd0;
							len_d   = 32'd0;
						end else begin
							phase_d = PH_SKIP;
						end
					end
				end
			end
			PH_FMT: begin
				fw_d[pos_q[3:2]] = fw_q[pos_q[3:2]] | part;
				pos_d = pos_q + 4'd1;
				if (pos_q == 4'd15) begin
					pos_d = {3'd0, len_q[0]};
					if (len_q == 32'd0) begin
						body_end = 1'b1;
					end else begin
						phase_d = PH_EXTRA;
					end
				end
			end
			PH_EXTRA, PH_SKIP: begin
				len_d = len_dec;
				if (len_dec == 32'd0) begin
					body_end = 1'b1;
					end_pad  = pos_q[0];
				end
			end
			PH_PAD: begin
				finish = 1'b1;
			end
			PH_DATA: begin
				if (!pos_q[0]) begin
					low_d = byte_s1;
				end else begin
					smp_vld_c = 1'b1;
					smp_c     = {byte_s1, low_q};
				end
				pos_d = {3'd0, !pos_q[0]};
				len_d = len_dec;
				if (len_dec == 32'd0) status_c = ST_ACCEPT;
			end
			default: begin
			end
		endcase

		// An odd body is followed by one pad byte before the chunk is closed.
		if (body_end) begin
			if (end_pad) begin
				phase_d = PH_PAD;
			end else begin
				finish = 1'b1;
			end
		end

		if (finish) begin
			if (id_q == ID_FMT && !fmt_ok(fw_d)) begin
				status_c = ST_FMT;
			end else begin
				if (id_q == ID_FMT) seen_d = 1'b1;
				phase_d = PH_CHUNK;
				pos_d   = 4'd0;
				id_d    = 32'd0;
				len_d   = 32'd0;
			end
		end

		if (eof_s1 && status_c == ST_NONE) begin
			status_c = ST_TRUNC;
		end
		st_c = (status_c != ST_NONE);
	end

	assign result_c = !verdict_q && (smp_vld_c || st_c);
	// A file is done on its flagged byte, whether or not a verdict was pending.
	assign restart  = eof_s1 && (verdict_q || st_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			eof_s1  <= end_of_file;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			pos_q     <= 4'd0;
			id_q      <= 32'd0;
			len_q     <= 32'd0;
			fw_q      <= '0;
			seen_q    <= 1'b0;
			low_q     <= 8'd0;
			verdict_q <= 1'b0;
		end else if (fire_s1) begin
			if (restart) begin
				phase_q   <= PH_HEADER;
				pos_q     <= 4'd0;
				id_q      <= 32'd0;
				len_q     <= 32'd0;
				fw_q      <= '0;
				seen_q    <= 1'b0;
				low_q     <= 8'd0;
				verdict_q <= 1'b0;
			end else if (!verdict_q) begin
				phase_q   <= phase_d;
				pos_q     <= pos_d;
				id_q      <= id_d;
				len_q     <= len_d;
				fw_q      <= fw_d;
				seen_q    <= seen_d;
				low_q     <= low_d;
				verdict_q <= st_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && result_c) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && result_c) begin
			smp_vld_q <= smp_vld_c;
			smp_q     <= smp_c;
			st_q      <= status_c;
			rate_q    <= (status_c == ST_ACCEPT) ? fw_q[1] : 32'd0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_valid = smp_vld_q;
	assign sample       = smp_q;
	assign status       = st_q;
	assign sample_rate  = rate_q;

	a_result_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sample_valid || status != ST_NONE))
		else $error("result request carries neither a sample nor a status");

	a_rate_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_ACCEPT) |-> (sample_rate == 32'd0))
		else $error("sample rate reported without an accept status");

	a_sample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !sample_valid) |-> (sample == 16'sd0))
		else $error("sample field nonzero without a sample");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the result register is empty");

endmodule

`default_nettype wire

// File: sim/wav_mono_pcm16_stream_parser_core_test.sv
// Self-checking testbench for the mono PCM16 WAV stream parser core.
`timescale 1ns / 100ps

module wav_mono_pcm16_stream_parser_core_test;
	import wavp_pkg::*;

	localparam int PARSED_TARGET = 1550;
	localparam int DRAIN_LIMIT   = 20000;

	typedef struct packed {
		logic                smp_valid;
		logic [15:0]         smp;
		logic [STATUS_W-1:0] st;
		logic [31:0]         rate;
	} parse_result_t;

	typedef enum int {
		FK_GOOD, FK_BAD_RIFF_ID, FK_RIFF_SMALL, FK_BAD_WAVE, FK_FMT_SHORT, FK_FMT_FIELD,
		FK_DATA_NO_FMT, FK_DATA_ODD, FK_DATA_EMPTY, FK_TRUNC, FK_FLIP, FK_NOISE
	} file_kind_t;

	typedef enum int {
		FL_NONE, FL_SHORT, FL_CODE, FL_CHANS, FL_RATE0, FL_BRATE, FL_ALIGN, FL_BITS
	} fmt_flaw_t;

	// Tracks the parse state of the file being streamed and holds the results it predicts.
	class wav_scoreboard;
		phase_t              phase;
		logic [31:0]         pos;
		logic [31:0]         id_word;
		logic [31:0]         remaining;
		fmt_words_t          fmt;
		bit                  fmt_seen;
		logic [7:0]          low_hold;
		bit                  verdict_done;
		logic [STATUS_W-1:0] verdict;
		bit                  smp_now;
		logic [15:0]         smp_val;
		parse_result_t       pending_results[$];
		int                  errors;
		int                  parsed_bytes;

		function new();
			errors = 0;
			parsed_bytes = 0;
			clear();
		endfunction

		function void clear();
			phase = PH_HEADER;
			pos = '0;
			id_word = '0;
			remaining = '0;
			fmt = '0;
			fmt_seen = 1'b0;
			low_hold = '0;
			verdict_done = 1'b0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void open_chunk_header();
			phase = PH_CHUNK;
			pos = '0;
			id_word = '0;
			remaining = '0;
		endfunction

		function void close_chunk();
			logic [31:0] rate;
			if (id_word == ID_FMT) begin
				rate = fmt[1];
				if (fmt[0][15:0] != FMT_PCM || fmt[0][31:16] != FMT_CHANNELS ||
						fmt[3][31:16] != FMT_BITS || rate == 32'd0 ||
						fmt[3][15:0] != FMT_ALIGN || fmt[2] != rate * 32'd2) begin
					verdict = ST_FMT;
					return;
				end
				fmt_seen = 1'b1;
			end
			open_chunk_header();
		endfunction

		// When end_body is called, pos holds the pad flag of the chunk.
		function void end_body();
			if (pos[0])
				phase = PH_PAD;
			else
				close_chunk();
		endfunction

		function void open_body();
			if (id_word == ID_FMT) begin
				if (remaining < FMT_MIN) begin
					verdict = ST_FMT;
					return;
				end
				fmt = '0;
				remaining = remaining - FMT_MIN;
				pos = '0;
				phase = PH_FMT;
			end else if (id_word == ID_DATA) begin
				if (!fmt_seen || remaining[0]) begin
					verdict = ST_DATA;
					return;
				end
				if (remaining == 32'd0) begin
					verdict = ST_EMPTY;
					return;
				end
				pos = '0;
				phase = PH_DATA;
			end else begin
				pos = {31'd0, remaining[0]};
				if (remaining == 32'd0)
					open_chunk_header();
				else
					phase = PH_SKIP;
			end
		endfunction

		function void parse_byte(input logic [7:0] b);
			logic [31:0] p;
			logic [31:0] part;
			p = pos;
			part = {24'd0, b} << (8 * p[1:0]);
			case (phase)
				PH_HEADER: begin
					if (p < 32'd4 || p >= 32'd8)
						id_word = id_word | part;
					else
						remaining = remaining | part;
					pos = p + 32'd1;
					if (p == 32'd3) begin
						if (id_word != ID_RIFF)
							verdict = ST_RIFF;
						id_word = '0;
					end else if (p == 32'd7) begin
						if (remaining < RIFF_MIN)
							verdict = ST_RIFF;
					end else if (p >= 32'd11) begin
						if (id_word != ID_WAVE)
							verdict = ST_RIFF;
						else
							open_chunk_header();
					end
				end
				PH_CHUNK: begin
					if (p < 32'd4)
						id_word = id_word | part;
					else
						remaining = remaining | part;
					pos = p + 32'd1;
					if (p >= 32'd7)
						open_body();
				end
				PH_FMT: begin
					fmt[p[3:2]] = fmt[p[3:2]] | part;
					pos = p + 32'd1;
					if (p >= FMT_MIN - 32'd1) begin
						pos = {31'd0, remaining[0]};
						if (remaining == 32'd0)
							end_body();
						else
							phase = PH_EXTRA;
					end
				end
				PH_EXTRA, PH_SKIP: begin
					remaining = remaining - 32'd1;
					if (remaining == 32'd0)
						end_body();
				end
				PH_PAD: begin
					close_chunk();
				end
				PH_DATA: begin
					if (!p[0]) begin
						low_hold = b;
					end else begin
						smp_now = 1'b1;
						smp_val = {b, low_hold};
					end
					pos = p ^ 32'd1;
					remaining = remaining - 32'd1;
					if (remaining == 32'd0)
						verdict = ST_ACCEPT;
				end
				default: begin
				end
			endcase
		endfunction

		function void note_request(input logic [7:0] b, input logic eof);
			parse_result_t r;
			parsed_bytes++;
			if (verdict_done) begin
				if (eof)
					clear();
				return;
			end
			verdict = ST_NONE;
			smp_now = 1'b0;
			smp_val = '0;
			parse_byte(b);
			if (eof && verdict == ST_NONE)
				verdict = ST_TRUNC;
			r.smp_valid = smp_now;
			r.smp = smp_val;
			r.st = verdict;
			r.rate = (verdict == ST_ACCEPT) ? fmt[1] : 32'd0;
			if (verdict != ST_NONE) begin
				if (eof)
					clear();
				else
					verdict_done = 1'b1;
			end
			if (r.smp_valid || r.st != ST_NONE)
				pending_results.push_back(r);
		endfunction

		function void check_result(input logic sv, input logic [15:0] smp,
				input logic [STATUS_W-1:0] st, input logic [31:0] rate);
			parse_result_t want;
			if (pending_results.size() == 0) begin
				$error("unexpected result: sample_valid %0d sample %h status %0d", sv, smp, st);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (sv !== want.smp_valid) begin
				$error("sample_valid: expected %0d, got %0d", want.smp_valid, sv);
				errors++;
			end
			if (smp !== want.smp) begin
				$error("sample: expected %h, got %h", want.smp, smp);
				errors++;
			end
			if (st !== want.st) begin
				$error("status: expected %0d, got %0d", want.st, st);
				errors++;
			end
			if (rate !== want.rate) begin
				$error("sample_rate: expected %h, got %h", want.rate, rate);
				errors++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [7:0]             data_byte = '0;
	logic                   end_of_file = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   sample_valid;
	logic signed [15:0]     sample;
	logic [STATUS_W-1:0]    status;
	logic [31:0]            sample_rate;

	wav_scoreboard board = new();
	logic [7:0]    file_bytes[$];
	int            burst_left = 4;
	int            stall_mode = 0;
	int            stall_span = 0;

	wav_mono_pcm16_stream_parser_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.end_of_file  (end_of_file),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_valid (sample_valid),
		.sample       (sample),
		.status       (status),
		.sample_rate  (sample_rate)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void add_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			file_bytes.push_back(w[8*i +: 8]);
	endfunction

	function automatic void add_half(input logic [15:0] h);
		file_bytes.push_back(h[7:0]);
		file_bytes.push_back(h[15:8]);
	endfunction

	function automatic void add_junk();
		repeat ($urandom_range(0, 3))
			file_bytes.push_back(8'($urandom));
	endfunction

	function automatic logic [31:0] pick_rate();
		case ($urandom_range(0, 5))
			0: return 32'd1;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return $urandom_range(32'hFFFF_FFFF, 1);
			default: return $urandom_range(8000, 192000);
		endcase
	endfunction

	// Unknown chunk, skipped by the parser together with its pad byte.
	function automatic void add_other_chunk();
		logic [31:0] cid;
		int len;
		if ($urandom_range(0, 4) == 0)
			cid = ID_RIFF;
		else
			cid = $urandom;
		if (cid == ID_FMT || cid == ID_DATA)
			cid = ID_WAVE;
		len = $urandom_range(0, 6);
		add_word(cid);
		add_word(len);
		repeat (len)
			file_bytes.push_back(8'($urandom));
		if (len % 2 == 1)
			file_bytes.push_back(8'($urandom));
	endfunction

	function automatic void add_fmt(input fmt_flaw_t flaw, input logic [31:0] rate, input int extra);
		logic [15:0] code, chans, align, bits;
		logic [31:0] brate, r;
		code = FMT_PCM;
		chans = FMT_CHANNELS;
		align = FMT_ALIGN;
		bits = FMT_BITS;
		r = rate;
		brate = rate * 32'd2;
		add_word(ID_FMT);
		if (flaw == FL_SHORT) begin
			add_word($urandom_range(0, 15));
			return;
		end
		case (flaw)
			FL_CODE: code = ($urandom_range(0, 1)) ? 16'd3 : 16'($urandom) | 16'd2;
			FL_CHANS: chans = ($urandom_range(0, 1)) ? 16'd2 : 16'd0;
			FL_RATE0: begin
				r = 32'd0;
				brate = 32'd0;
			end
			FL_BRATE: brate = brate ^ (32'd1 << $urandom_range(0, 31));
			FL_ALIGN: align = ($urandom_range(0, 1)) ? 16'd4 : 16'd1;
			FL_BITS: bits = ($urandom_range(0, 1)) ? 16'd8 : 16'hFFFF;
			default: begin
			end
		endcase
		add_word(FMT_MIN + extra);
		add_half(code);
		add_half(chans);
		add_word(r);
		add_word(brate);
		add_half(align);
		add_half(bits);
		repeat (extra)
			file_bytes.push_back(8'($urandom));
		if (extra % 2 == 1)
			file_bytes.push_back(8'($urandom));
	endfunction

	function automatic void build_file(input file_kind_t kind, input bit directed);
		logic [31:0] riff_size, dlen;
		fmt_flaw_t flaw;
		int cut;
		file_bytes.delete();
		if (kind == FK_NOISE) begin
			if ($urandom_range(0, 1)) begin
				add_word(ID_RIFF);
				add_word($urandom);
				add_word(ID_WAVE);
			end
			repeat ($urandom_range(1, 30))
				file_bytes.push_back(8'($urandom));
			return;
		end
		if (directed || $urandom_range(0, 3) == 0)
			riff_size = directed ? 32'hFFFF_FFFF : RIFF_MIN;
		else
			riff_size = $urandom_range(32'hFFFF_FFFF, RIFF_MIN);
		add_word((kind == FK_BAD_RIFF_ID) ? ID_RIFF ^ (32'd1 << $urandom_range(0, 31)) : ID_RIFF);
		add_word((kind == FK_RIFF_SMALL) ? $urandom_range(0, 3) : riff_size);
		add_word((kind == FK_BAD_WAVE) ? ID_WAVE ^ (32'd1 << $urandom_range(0, 31)) : ID_WAVE);
		if (kind == FK_BAD_RIFF_ID || kind == FK_RIFF_SMALL || kind == FK_BAD_WAVE) begin
			add_junk();
			return;
		end
		repeat ($urandom_range(0, 1))
			add_other_chunk();
		if (kind != FK_DATA_NO_FMT) begin
			flaw = FL_NONE;
			if (kind == FK_FMT_SHORT)
				flaw = FL_SHORT;
			else if (kind == FK_FMT_FIELD)
				flaw = fmt_flaw_t'($urandom_range(FL_CODE, FL_BITS));
			add_fmt(flaw, directed ? 32'hFFFF_FFFF : pick_rate(),
				directed ? 1 : $urandom_range(0, 3));
			if (flaw != FL_NONE) begin
				add_junk();
				return;
			end
			// A later fmt chunk replaces the rate of the first one.
			if ($urandom_range(0, 5) == 0)
				add_fmt(FL_NONE, pick_rate(), $urandom_range(0, 3));
			repeat ($urandom_range(0, 1))
				add_other_chunk();
		end
		case (kind)
			FK_DATA_ODD: dlen = 2 * $urandom_range(0, 4) + 1;
			FK_DATA_EMPTY: dlen = 0;
			default: dlen = directed ? 8 : 2 * $urandom_range(1, 7);
		endcase
		add_word(ID_DATA);
		add_word(dlen);
		if (directed && kind == FK_GOOD) begin
			// Most negative, most positive, minus one and zero.
			add_word(32'h7FFF_8000);
			add_word(32'h0000_FFFF);
		end else begin
			repeat (dlen)
				file_bytes.push_back(8'($urandom));
		end
		add_junk();
		if (kind == FK_TRUNC) begin
			cut = $urandom_range(1, file_bytes.size() - 1);
			file_bytes = file_bytes[0:cut-1];
		end
		if (kind == FK_FLIP)
			file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
	endfunction

	function automatic file_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return FK_GOOD;
		if (r < 55)
			return FK_TRUNC;
		if (r < 68)
			return FK_FLIP;
		if (r < 72)
			return FK_NOISE;
		return file_kind_t'($urandom_range(FK_BAD_RIFF_ID, FK_DATA_EMPTY));
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eof);
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_file <= eof;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_request(b, eof);
	endtask

	// Bursts of requests separated by idle gaps; now and then a long burst with no gap.
	task automatic pace();
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 16);
		end
	endtask

	task automatic send_file();
		for (int i = 0; i < file_bytes.size(); i++) begin
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
			pace();
		end
	endtask

	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_span <= $urandom_range(20, 200);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			board.check_result(sample_valid, sample, status, sample_rate);

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int waited;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int k = FK_GOOD; k <= FK_NOISE; k++) begin
			build_file(file_kind_t'(k), 1'b1);
			send_file();
		end
		while (board.parsed_bytes < PARSED_TARGET) begin
			build_file(pick_kind(), 1'b0);
			send_file();
		end
		in_valid <= 1'b0;
		waited = 0;
		while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (board.pending() != 0) begin
			$error("%0d expected results never arrived", board.pending());
			board.errors++;
		end
		repeat (10)
			@(posedge clk);
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
